>>> design/fdw_pkg.sv
// ----------------------------------------------------------------------------
// Float to decimal word encoder package
// Shared states, command and status types and constants.
// ----------------------------------------------------------------------------
package fdw_pkg;

    localparam int unsigned SigW  = 24;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned ProdW = 61;

    localparam logic [31:0] OneMillionBits     = 32'h4974_2400;
    localparam logic [31:0] HundredThousandBits = 32'h47C3_5000;
    localparam logic [31:0] RecipTen           = 32'hCCCC_CCCD;
    localparam logic [ExpW-1:0] ExpAll         = 8'hFF;
    localparam logic [ExpW-1:0] BiasShift      = 8'd150;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_CLASS,
        t_ST_CHK_DIV,
        t_ST_DIV_A,
        t_ST_DIV_B,
        t_ST_CHK_MUL,
        t_ST_MUL_A,
        t_ST_MUL_B
    } t_state;

    typedef struct packed {
        logic load;
        logic div_mul;
        logic div_upd;
        logic mul_mul;
        logic mul_upd;
        logic out_wr;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic ge_million;
        logic lt_hundred_k;
    } t_status;

endpackage

>>> design/float_to_decimal_word_encoder.sv
// Zero, infinity and NaN are written straight from the classify state; other values pass
// through the divide and multiply by ten scaling steps first, one step at a time.
// Each step has a multiply state and an update state and uses the shared product register;
// a value needs up to about fifty steps.
// One request is worked on at a time; the next can be taken the cycle after a result is written.
// Reset is synchronous and active low and clears the controller and output valid.
// ----------------------------------------------------------------------------
// Float to decimal word encoder
// Converts a single-precision value into a packed decimal mantissa/exponent word.
// ----------------------------------------------------------------------------
module float_to_decimal_word_encoder import fdw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_packed_word,
    output logic        o_not_finite
);

    t_cmd    cmd;
    t_status status;

    fdw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fdw_datapath u_datapath (
        .i_clk         (i_clk),
        .i_float_bits  (i_float_bits),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_packed_word (o_packed_word),
        .o_not_finite  (o_not_finite)
    );

endmodule

>>> design/fdw_datapath.sv
// ----------------------------------------------------------------------------
// Float to decimal word datapath
// Holds the magnitude as significand and biased exponent, performs rounded
// multiply and divide by ten steps, and forms the packed output word.
// ----------------------------------------------------------------------------
module fdw_datapath import fdw_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_float_bits,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [31:0] o_packed_word,
    output logic        o_not_finite
);

    logic [SigW-1:0]  r_sig,  n_sig;
    logic [ExpW-1:0]  r_eb,   n_eb;
    logic [ExpW-1:0]  r_dexp, n_dexp;
    logic             r_neg,  r_nan, r_zero;
    logic [ProdW-1:0] r_prod, n_prod;
    logic [31:0]      r_word;
    logic             r_nf;

    logic [ExpW-1:0]  field;
    logic [31:0]      mag_bits;
    logic [28:0]      num;
    logic [25:0]      quo;
    logic [28:0]      rem_full;
    logic             rem_nz;
    logic [SigW-1:0]  rm;
    logic             rg, rs, up;
    logic [SigW:0]    rsum;
    logic [ExpW-1:0]  reb;
    logic [27:0]      p;
    logic [ExpW-1:0]  sh;
    logic [SigW-1:0]  mant, smant;

    assign field    = r_sig[SigW-1] ? r_eb : '0;
    assign mag_bits = {1'b0, field, r_sig[SigW-2:0]};
    assign o_status.special      = r_nan | r_zero;
    assign o_status.ge_million   = mag_bits >= OneMillionBits;
    assign o_status.lt_hundred_k = mag_bits <  HundredThousandBits;

    assign num      = {r_sig, 5'b0};
    assign quo      = r_prod[60:35];
    assign rem_full = num - ({quo, 3'b0} + {2'b0, quo, 1'b0});
    assign rem_nz   = |rem_full[3:0];
    assign p        = r_prod[27:0];

    always_comb begin
        rm  = '0;
        rg  = 1'b0;
        rs  = 1'b0;
        reb = r_eb;
        if (i_cmd.div_upd) begin
            if (quo[25]) begin
                rm  = quo[25:2];
                rg  = quo[1];
                rs  = quo[0] | rem_nz;
                reb = r_eb - 8'd3;
            end else begin
                rm  = quo[24:1];
                rg  = quo[0];
                rs  = rem_nz;
                reb = r_eb - 8'd4;
            end
        end else begin
            priority if (p[27]) begin
                rm = p[27:4]; rg = p[3]; rs = |p[2:0]; reb = r_eb + 8'd4;
            end else if (p[26]) begin
                rm = p[26:3]; rg = p[2]; rs = |p[1:0]; reb = r_eb + 8'd3;
            end else if (p[25]) begin
                rm = p[25:2]; rg = p[1]; rs = p[0];    reb = r_eb + 8'd2;
            end else if (p[24]) begin
                rm = p[24:1]; rg = p[0]; rs = 1'b0;    reb = r_eb + 8'd1;
            end else begin
                rm = p[23:0]; rg = 1'b0; rs = 1'b0;    reb = r_eb;
            end
        end
        up   = rg & (rs | rm[0]);
        rsum = {1'b0, rm} + {{SigW{1'b0}}, up};
    end

    always_comb begin
        n_sig  = r_sig;
        n_eb   = r_eb;
        n_dexp = r_dexp;
        n_prod = r_prod;
        if (i_cmd.load) begin
            n_sig  = {(i_float_bits[30:23] != '0), i_float_bits[22:0]};
            n_eb   = (i_float_bits[30:23] != '0) ? i_float_bits[30:23] : 8'd1;
            n_dexp = '0;
        end
        if (i_cmd.div_mul) begin
            n_prod = {32'b0, num} * {29'b0, RecipTen};
        end
        if (i_cmd.mul_mul) begin
            n_prod = {{(ProdW-SigW){1'b0}}, r_sig} * {{(ProdW-4){1'b0}}, 4'd10};
        end
        if (i_cmd.div_upd || i_cmd.mul_upd) begin
            if (rsum[SigW]) begin
                n_sig = rsum[SigW:1];
                n_eb  = reb + 8'd1;
            end else begin
                n_sig = rsum[SigW-1:0];
                n_eb  = reb;
            end
            n_dexp = i_cmd.div_upd ? r_dexp + 8'd1 : r_dexp - 8'd1;
        end
    end

    assign sh    = BiasShift - r_eb;
    assign mant  = r_sig >> sh;
    assign smant = r_neg ? (~mant + 24'd1) : mant;

    always_ff @(posedge i_clk) begin
        r_sig  <= n_sig;
        r_eb   <= n_eb;
        r_dexp <= n_dexp;
        r_prod <= n_prod;
        if (i_cmd.load) begin
            r_neg  <= i_float_bits[31];
            r_nan  <= i_float_bits[30:23] == ExpAll;
            r_zero <= i_float_bits[30:0] == '0;
        end
        if (i_cmd.out_wr) begin
            r_nf   <= r_nan;
            r_word <= (r_nan || r_zero) ? 32'd0 : {r_dexp, smant};
        end
    end

    assign o_packed_word = r_word;
    assign o_not_finite  = r_nf;

endmodule

>>> design/fdw_ctrl.sv
// ----------------------------------------------------------------------------
// Float to decimal word controller
// Sequences the scaling steps and owns both handshakes.
// ----------------------------------------------------------------------------
module fdw_ctrl import fdw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   finish;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        finish = 1'b0;
        unique case (r_state)
            t_ST_CLASS:   finish = i_status.special;
            t_ST_CHK_MUL: finish = !i_status.lt_hundred_k;
            default:      finish = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE:    if (i_valid) n_state = t_ST_CLASS;
            t_ST_CLASS: begin
                if (i_status.special) begin
                    if (out_free) n_state = t_ST_IDLE;
                end else begin
                    n_state = t_ST_CHK_DIV;
                end
            end
            t_ST_CHK_DIV: n_state = i_status.ge_million ? t_ST_DIV_A : t_ST_CHK_MUL;
            t_ST_DIV_A:   n_state = t_ST_DIV_B;
            t_ST_DIV_B:   n_state = t_ST_CHK_DIV;
            t_ST_CHK_MUL: begin
                if (i_status.lt_hundred_k) begin
                    n_state = t_ST_MUL_A;
                end else if (out_free) begin
                    n_state = t_ST_IDLE;
                end
            end
            t_ST_MUL_A:   n_state = t_ST_MUL_B;
            t_ST_MUL_B:   n_state = t_ST_CHK_MUL;
            default:      n_state = t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == t_ST_IDLE) && i_valid;
        o_cmd.div_mul = r_state == t_ST_DIV_A;
        o_cmd.div_upd = r_state == t_ST_DIV_B;
        o_cmd.mul_mul = r_state == t_ST_MUL_A;
        o_cmd.mul_upd = r_state == t_ST_MUL_B;
        o_cmd.out_wr  = finish && out_free;
        n_out_valid   = o_cmd.out_wr ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = r_state != t_ST_IDLE;
    assign o_valid = r_out_valid;

endmodule
